// ===== design/arlh_pkg.sv =====
// shared types, constants and aes round functions for the lane hash
package arlh_pkg;

    localparam int LaneCount = 8;
    localparam int LaneBits  = $clog2(LaneCount);
    localparam int AddrBits  = $clog2(2 * LaneCount);
    localparam logic [63:0] GoldenStep = 64'h9E3779B97F4A7C15;

    localparam logic [2:0] RegSeed0   = 3'd0;
    localparam logic [2:0] RegSeed1   = 3'd1;
    localparam logic [2:0] RegSeed2   = 3'd2;
    localparam logic [2:0] RegSeed3   = 3'd3;
    localparam logic [2:0] RegUseSeed = 3'd4;

    typedef enum logic [3:0] {
        ST_INIT_LK,   // write lane and round key words from rom
        ST_CROSS_RD,  // read rk[i], lane[i], rk[i+1]
        ST_CROSS_WR,  // round and write cross key
        ST_IDLE,
        ST_ABS_RD,    // read lane and key for absorb
        ST_ABS_WR,    // round and write lane
        ST_FIN_RD,    // read operands of one tree node
        ST_FIN_WR,    // round one tree node
        ST_OUT        // digest waits for the sink
    } t_state;

    typedef struct packed {
        logic [127:0] blk;
        logic [127:0] key;
    } t_round_in;

    function automatic logic [7:0] rom_byte(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h24,8'h3F,8'h6A,8'h88,8'h85,8'hA3,8'h08,8'hD3,8'h13,8'h19,8'h8A,8'h2E,8'h03,8'h70,8'h73,8'h44,
        8'hA4,8'h09,8'h38,8'h22,8'h29,8'h9F,8'h31,8'hD0,8'h08,8'h2E,8'hFA,8'h98,8'hEC,8'h4E,8'h6C,8'h89,
        8'h45,8'h28,8'h21,8'hE6,8'h38,8'hD0,8'h13,8'h77,8'hBE,8'h54,8'h66,8'hCF,8'h34,8'hE9,8'h0C,8'h6C,
        8'hC0,8'hAC,8'h29,8'hB7,8'hC9,8'h7C,8'h50,8'hDD,8'h3F,8'h84,8'hD5,8'hB5,8'hB5,8'h47,8'h09,8'h17,
        8'h92,8'h16,8'hD5,8'hD9,8'h89,8'h79,8'hFB,8'h1B,8'hD1,8'h31,8'h0B,8'hA6,8'h98,8'hDF,8'hB5,8'hAC,
        8'h2F,8'hFD,8'h72,8'hDB,8'hD0,8'h1A,8'hDF,8'hB7,8'hB8,8'hE1,8'hAF,8'hED,8'h6A,8'h26,8'h7E,8'h96,
        8'hBA,8'h7C,8'h90,8'h45,8'hF1,8'h2C,8'h7F,8'h99,8'h24,8'hA1,8'h99,8'h47,8'hB3,8'h91,8'h6C,8'hF7,
        8'h08,8'h01,8'hF2,8'hE2,8'h85,8'h8E,8'hFC,8'h16,8'h63,8'h69,8'h20,8'hD8,8'h71,8'h57,8'h4E,8'h69,
        8'hA4,8'h58,8'hFE,8'hA3,8'hF4,8'h93,8'h3D,8'h7E,8'h0D,8'h95,8'h74,8'h8F,8'h72,8'h8E,8'hB6,8'h58,
        8'h71,8'h8B,8'hCD,8'h58,8'h82,8'h15,8'h4A,8'hEE,8'h7B,8'h54,8'hA4,8'h1D,8'hC2,8'h5A,8'h59,8'hB5,
        8'h9C,8'h30,8'hD5,8'h39,8'h2A,8'hF2,8'h60,8'h13,8'hC5,8'hD1,8'hB0,8'h23,8'h28,8'h60,8'h85,8'hF0,
        8'hCA,8'h41,8'h79,8'h18,8'hB8,8'hDB,8'h38,8'hEF,8'h8E,8'h79,8'hDC,8'hB0,8'h60,8'h3A,8'h18,8'h0E,
        8'h6C,8'h9E,8'h0E,8'h8B,8'hB0,8'h1E,8'h8A,8'h3E,8'hD7,8'h15,8'h77,8'hC1,8'hBD,8'h31,8'h4B,8'h27,
        8'h78,8'hAF,8'h2F,8'hDA,8'h55,8'h60,8'h5C,8'h60,8'hE6,8'h55,8'h25,8'hF3,8'hAA,8'h55,8'hAB,8'h94,
        8'h57,8'h48,8'h98,8'h62,8'h63,8'hE8,8'h14,8'h40,8'h55,8'hCA,8'h39,8'h6A,8'h2A,8'hAB,8'h10,8'hB6,
        8'hB4,8'hCC,8'h5C,8'h34,8'h11,8'h41,8'hE8,8'hCE,8'hA1,8'h54,8'h86,8'hAF,8'h7C,8'h72,8'hE9,8'h93};
        return t[a];
    endfunction

    // 16 rom bytes starting at a 16-byte aligned offset, little endian
    function automatic logic [127:0] rom_block(input logic [3:0] blk);
        logic [127:0] r;
        for (int i = 0; i < 16; i++) r[8*i +: 8] = rom_byte({blk, i[3:0]});
        return r;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] s [256];
        s = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return s[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    // one aes encryption round: subbytes, shiftrows, mixcolumns, key xor
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k);
        logic [7:0] t [16];
        logic [127:0] r;
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++)
            t[i] = sbox(s[8*((i % 4) + 4*(((i / 4) + (i % 4)) % 4)) +: 8]);
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            r[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            r[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            r[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            r[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return r ^ k;
    endfunction

endpackage

// ===== design/aes_round_lane_hash.sv =====
// top level: lane hash with lane, key and cross key memories and a sequencer
//
//  channel   dir  handshake             payload
//  s_axis    in   s_axis_tvalid/tready  tdata {chunk_high,chunk_low}, tuser valid_bytes, tlast last
//  m_axis    out  m_axis_tvalid/tready  tdata {digest_high,digest_low}
//  cfg       in   i_cfg_we              i_cfg_index, i_cfg_data
//
//  a chunk that is not last goes through accept, memory read, then round and write back.
//  a last chunk does the same for its own lane (an empty message at lane 0 skips all lanes),
//  then a read and a round for each padding lane and for each of the 8 tree nodes; the digest then
//  waits in the output register. after reset, a write to registers 0 to 4 and each digest a rederive
//  pass runs (rom writes, then one cross key round per lane) while s_axis_tready is low.
//  the rounds of all of these steps use the one shared aes round unit.
module aes_round_lane_hash (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // chunk_low, chunk_high
    input  logic [4:0]   s_axis_tuser,   // valid_bytes
    input  logic         s_axis_tlast,   // last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // digest_low, digest_high
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    localparam int LB = arlh_pkg::LaneBits;

    arlh_pkg::t_state r_state, n_state;
    logic [63:0]  r_seed [4];
    logic         r_use_seed;
    logic [63:0]  r_count, n_count;
    logic [LB-1:0] r_pos, n_pos;
    logic [LB-1:0] r_idx, n_idx;
    logic [2:0]   r_node, n_node;
    logic         r_pad, n_pad;
    logic [127:0] r_chunk, n_chunk;
    logic [127:0] r_acc, n_acc;
    logic [127:0] r_m [4];
    logic [127:0] n_mval;
    logic         n_mwe;
    logic [1:0]   n_msel;
    logic [127:0] r_dig, n_dig;

    // lane memory: ports a and b; key memory; cross key memory
    logic         lane_we, rk_we, ck_we;
    logic [LB-1:0] lane_wa, lane_ra, lane_rb, rk_wa, rk_ra, rk_rb, ck_wa, ck_ra;
    logic [127:0] lane_wd, rk_wd, ck_wd, lane_qa, lane_qb, rk_qa, rk_qb, ck_q, ck_qx;

    arlh_ram #(.Depth(arlh_pkg::LaneCount), .Width(128)) u_lane (
        .i_clk(i_clk), .i_we(lane_we), .i_waddr(lane_wa), .i_wdata(lane_wd),
        .i_raddr_a(lane_ra), .i_raddr_b(lane_rb), .o_rdata_a(lane_qa), .o_rdata_b(lane_qb));
    arlh_ram #(.Depth(arlh_pkg::LaneCount), .Width(128)) u_rkey (
        .i_clk(i_clk), .i_we(rk_we), .i_waddr(rk_wa), .i_wdata(rk_wd),
        .i_raddr_a(rk_ra), .i_raddr_b(rk_rb), .o_rdata_a(rk_qa), .o_rdata_b(rk_qb));
    arlh_ram #(.Depth(arlh_pkg::LaneCount), .Width(128)) u_ckey (
        .i_clk(i_clk), .i_we(ck_we), .i_waddr(ck_wa), .i_wdata(ck_wd),
        .i_raddr_a(ck_ra), .i_raddr_b(ck_ra), .o_rdata_a(ck_q), .o_rdata_b(ck_qx));

    // shared aes round unit
    arlh_pkg::t_round_in rin;
    logic [127:0] rout;
    assign rout = arlh_pkg::aes_round(rin.blk, rin.key);

    // seed masks for entry r_idx
    logic [63:0] k_mul, lane_lo, lane_hi, rk_lo, rk_hi;
    logic [127:0] rom_lane, rom_rk;
    always_comb begin
        k_mul    = 64'(r_idx) * arlh_pkg::GoldenStep;
        rom_lane = arlh_pkg::rom_block({1'b0, r_idx});
        rom_rk   = arlh_pkg::rom_block({1'b1, r_idx});
        lane_lo  = rom_lane[63:0];   lane_hi = rom_lane[127:64];
        rk_lo    = rom_rk[63:0];     rk_hi   = rom_rk[127:64];
        if (r_use_seed) begin
            lane_lo ^= r_seed[0] ^ ~k_mul;  lane_hi ^= r_seed[1] ^ k_mul;
            rk_lo   ^= r_seed[2] ^ ~k_mul;  rk_hi   ^= r_seed[3] ^ k_mul;
        end
    end

    // last chunk padding from rom
    logic [4:0]   vb;
    logic [127:0] pad_rom, in_chunk;
    always_comb begin
        vb = (s_axis_tlast && s_axis_tuser < 5'd16) ? s_axis_tuser : 5'd16;
        pad_rom = arlh_pkg::rom_block({1'b0, r_pos});
        for (int i = 0; i < 16; i++)
            in_chunk[8*i +: 8] = (5'(i) < vb) ? s_axis_tdata[8*i +: 8] : pad_rom[8*i +: 8];
    end

    assign s_axis_tready = (r_state == arlh_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == arlh_pkg::ST_OUT);
    assign m_axis_tdata  = r_dig;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_seed[i] <= '0;
            r_use_seed <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                arlh_pkg::RegSeed0:   r_seed[0] <= i_cfg_data;
                arlh_pkg::RegSeed1:   r_seed[1] <= i_cfg_data;
                arlh_pkg::RegSeed2:   r_seed[2] <= i_cfg_data;
                arlh_pkg::RegSeed3:   r_seed[3] <= i_cfg_data;
                arlh_pkg::RegUseSeed: r_use_seed <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic cfg_hit;
    assign cfg_hit = i_cfg_we && (i_cfg_index <= arlh_pkg::RegUseSeed);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arlh_pkg::ST_INIT_LK;
            r_idx   <= '0;
            r_pos   <= '0;
            r_count <= '0;
            r_node  <= '0;
            r_pad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_node  <= n_node;
            r_pad   <= n_pad;
        end
        r_chunk <= n_chunk;
        r_acc   <= n_acc;
        r_dig   <= n_dig;
        if (n_mwe) r_m[n_msel] <= n_mval;
    end

    // sequencer: next state, memory ports and round unit operands
    always_comb begin
        n_state = r_state; n_idx = r_idx; n_pos = r_pos; n_count = r_count;
        n_node = r_node; n_pad = r_pad; n_chunk = r_chunk; n_acc = r_acc; n_dig = r_dig;
        n_mwe = 1'b0; n_msel = r_node[1:0]; n_mval = rout;
        lane_we = 1'b0; rk_we = 1'b0; ck_we = 1'b0;
        lane_wa = r_idx; rk_wa = r_idx; ck_wa = r_idx;
        lane_wd = {lane_hi, lane_lo}; rk_wd = {rk_hi, rk_lo}; ck_wd = rout;
        lane_ra = r_idx; lane_rb = r_idx + LB'(4); rk_ra = r_idx; rk_rb = r_idx + LB'(1);
        ck_ra = r_idx;
        rin.blk = rk_qa ^ lane_qa; rin.key = rk_qb;
        case (r_state)
            arlh_pkg::ST_INIT_LK: begin
                lane_we = 1'b1; rk_we = 1'b1;
                n_idx = r_idx + LB'(1);
                if (r_idx == LB'(arlh_pkg::LaneCount - 1)) n_state = arlh_pkg::ST_CROSS_RD;
            end
            arlh_pkg::ST_CROSS_RD: n_state = arlh_pkg::ST_CROSS_WR;
            arlh_pkg::ST_CROSS_WR: begin
                ck_we = 1'b1;
                n_idx = r_idx + LB'(1);
                n_state = (r_idx == LB'(arlh_pkg::LaneCount - 1)) ?
                          arlh_pkg::ST_IDLE : arlh_pkg::ST_CROSS_RD;
            end
            arlh_pkg::ST_IDLE: begin
                lane_ra = r_pos; rk_ra = r_pos;
                if (s_axis_tvalid) begin
                    n_count = r_count + 64'(vb);
                    n_chunk = in_chunk;
                    n_idx   = r_pos;
                    n_pad   = 1'b0;
                    if (!s_axis_tlast) begin
                        n_state = arlh_pkg::ST_ABS_RD;
                    end else if (r_pos == '0 && vb == 5'd0) begin
                        n_node = '0; n_idx = '0; n_state = arlh_pkg::ST_FIN_RD;
                    end else begin
                        n_pad = 1'b1; n_state = arlh_pkg::ST_ABS_RD;
                    end
                end
            end
            arlh_pkg::ST_ABS_RD: n_state = arlh_pkg::ST_ABS_WR;
            arlh_pkg::ST_ABS_WR: begin
                rin.blk = lane_qa ^ r_chunk; rin.key = rk_qa;
                lane_we = 1'b1; lane_wd = rout;
                n_chunk = arlh_pkg::rom_block({1'b0, r_idx + LB'(1)});
                if (!r_pad) begin
                    n_pos = r_idx + LB'(1); n_state = arlh_pkg::ST_IDLE;
                end else if (r_idx == LB'(arlh_pkg::LaneCount - 1)) begin
                    n_node = '0; n_idx = '0; n_state = arlh_pkg::ST_FIN_RD;
                end else begin
                    n_idx = r_idx + LB'(1); n_state = arlh_pkg::ST_ABS_RD;
                end
            end
            arlh_pkg::ST_FIN_RD: begin
                lane_ra = LB'(r_node); lane_rb = LB'(r_node) + LB'(4); ck_ra = LB'(r_node);
                n_state = arlh_pkg::ST_FIN_WR;
            end
            arlh_pkg::ST_FIN_WR: begin
                rin.key = ck_q;
                case (r_node)
                    3'd0, 3'd1, 3'd2, 3'd3: rin.blk = lane_qa ^ lane_qb;
                    3'd4: rin.blk = r_m[0] ^ r_m[2];
                    3'd5: rin.blk = r_m[1] ^ r_m[3];
                    3'd6: rin.blk = r_m[0] ^ r_m[1];
                    default: rin.blk = r_acc ^ {r_count, ~r_count};
                endcase
                n_mwe = 1'b1;
                n_msel = (r_node == 3'd4) ? 2'd0 : (r_node == 3'd5) ? 2'd1 : r_node[1:0];
                n_acc = rout;
                n_node = r_node + 3'd1;
                if (r_node == 3'd6) n_mwe = 1'b0;
                if (r_node == 3'd7) begin
                    n_mwe = 1'b0; n_dig = rout; n_state = arlh_pkg::ST_OUT;
                end else begin
                    n_state = arlh_pkg::ST_FIN_RD;
                end
            end
            arlh_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_idx = '0; n_pos = '0; n_count = '0; n_state = arlh_pkg::ST_INIT_LK;
                end
            end
            default: n_state = arlh_pkg::ST_INIT_LK;
        endcase
        // a write to registers 0 to 4 drops the message and rederives
        if (cfg_hit) begin
            n_idx = '0; n_pos = '0; n_count = '0; n_state = arlh_pkg::ST_INIT_LK;
            lane_we = 1'b0; rk_we = 1'b0; ck_we = 1'b0;
        end
    end
endmodule

// ===== design/arlh_ram.sv =====
// generic dual read port ram, one write port, registered reads
module arlh_ram #(
    parameter int Depth = 8,
    parameter int Width = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr_a,
    input  logic [$clog2(Depth)-1:0] i_raddr_b,
    output logic [Width-1:0]         o_rdata_a,
    output logic [Width-1:0]         o_rdata_b
);
    logic [Width-1:0] mem [Depth];

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end
endmodule

// ===== sim/tb_aes_round_lane_hash.sv =====
// testbench for the aes round lane hash: scoreboard against a behavioral digest predictor
module tb_aes_round_lane_hash;

    localparam int CycleLimit = 1500000;

    typedef struct packed {
        logic [63:0] chunk_high;
        logic [63:0] chunk_low;
        logic [4:0]  valid_bytes;
        logic        last;
    } t_chunk;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [4:0]   s_axis_tuser = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;

    aes_round_lane_hash i_dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [63:0]  seed_words [4];
    logic         seed_on;
    logic [127:0] lanes [8];
    logic [127:0] rkeys [8];
    logic [127:0] xkeys [8];
    logic [63:0]  msg_len;
    int unsigned  lane_ptr;

    t_chunk       pending_chunks [$];
    logic [127:0] digest_queue [$];
    int unsigned  n_errors = 0;
    int unsigned  cycle_count = 0;
    bit           sink_hold = 1'b0;
    bit           send_pause = 1'b0;
    int unsigned  send_gap = 0;
    int unsigned  sink_gap = 0;

    // own sbox: multiplicative inverse then affine map
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] inv, q;
        inv = 8'h00;
        for (int c = 1; c < 256; c++)
            if (gmul(x, c[7:0]) == 8'h01) inv = c[7:0];
        q = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return q;
    endfunction

    logic [7:0] sub_lut [256];
    initial for (int i = 0; i < 256; i++) sub_lut[i] = sub_byte(i[7:0]);

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k);
        logic [7:0] t [16];
        logic [127:0] r;
        logic [7:0] b0, b1, b2, b3;
        for (int i = 0; i < 16; i++)
            t[i] = sub_lut[s[8*((i % 4) + 4*(((i / 4) + (i % 4)) % 4)) +: 8]];
        for (int c = 0; c < 4; c++) begin
            b0 = t[4*c]; b1 = t[4*c+1]; b2 = t[4*c+2]; b3 = t[4*c+3];
            r[32*c +: 8]    = gmul(b0, 8'h02) ^ gmul(b1, 8'h03) ^ b2 ^ b3;
            r[32*c+8 +: 8]  = b0 ^ gmul(b1, 8'h02) ^ gmul(b2, 8'h03) ^ b3;
            r[32*c+16 +: 8] = b0 ^ b1 ^ gmul(b2, 8'h02) ^ gmul(b3, 8'h03);
            r[32*c+24 +: 8] = gmul(b0, 8'h03) ^ b1 ^ b2 ^ gmul(b3, 8'h02);
        end
        return r ^ k;
    endfunction

    function automatic logic [127:0] pi_block(input int unsigned blk);
        logic [127:0] r;
        for (int i = 0; i < 16; i++) r[8*i +: 8] = arlh_pkg::rom_byte(8'(16 * blk + i));
        return r;
    endfunction

    // rebuild lanes and keys from the rom and the seed
    task automatic rederive();
        logic [63:0] k;
        for (int i = 0; i < 8; i++) begin
            k = 64'(i) * arlh_pkg::GoldenStep;
            lanes[i] = pi_block(i);
            rkeys[i] = pi_block(8 + i);
            if (seed_on) begin
                lanes[i] ^= {seed_words[1] ^ k, seed_words[0] ^ ~k};
                rkeys[i] ^= {seed_words[3] ^ k, seed_words[2] ^ ~k};
            end
        end
        for (int i = 0; i < 8; i++)
            xkeys[i] = enc_round(rkeys[i] ^ lanes[i], rkeys[(i + 1) % 8]);
        msg_len = '0;
        lane_ptr = 0;
    endtask

    task automatic predict_chunk(input t_chunk c);
        logic [127:0] blk, rom_fill, m0, m1, m2, m3, r;
        int unsigned  v;
        v = c.valid_bytes;
        if (v > 16 || !c.last) v = 16;
        blk = {c.chunk_high, c.chunk_low};
        rom_fill = pi_block(lane_ptr);
        for (int i = 0; i < 16; i++)
            if (i >= v) blk[8*i +: 8] = rom_fill[8*i +: 8];
        msg_len += 64'(v);
        if (!c.last) begin
            lanes[lane_ptr] = enc_round(lanes[lane_ptr] ^ blk, rkeys[lane_ptr]);
            lane_ptr = (lane_ptr + 1) % 8;
        end else begin
            if (16 * lane_ptr + v > 0) begin
                lanes[lane_ptr] = enc_round(lanes[lane_ptr] ^ blk, rkeys[lane_ptr]);
                for (int i = lane_ptr + 1; i < 8; i++)
                    lanes[i] = enc_round(lanes[i] ^ pi_block(i), rkeys[i]);
            end
            m0 = enc_round(lanes[0] ^ lanes[4], xkeys[0]);
            m1 = enc_round(lanes[1] ^ lanes[5], xkeys[1]);
            m2 = enc_round(lanes[2] ^ lanes[6], xkeys[2]);
            m3 = enc_round(lanes[3] ^ lanes[7], xkeys[3]);
            r = enc_round(enc_round(m0 ^ m2, xkeys[4]) ^ enc_round(m1 ^ m3, xkeys[5]), xkeys[6]);
            r = enc_round(r ^ {msg_len, ~msg_len}, xkeys[7]);
            digest_queue.push_back(r);
            rederive();
        end
    endtask

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 99) < 55) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver: offer pending items, predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_chunk({s_axis_tdata, s_axis_tuser,
                                                               s_axis_tlast});
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0 || send_pause || pending_chunks.size() == 0) begin
                    if (send_gap > 0) send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    t_chunk c;
                    c = pending_chunks.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {c.chunk_high, c.chunk_low};
                    s_axis_tuser <= c.valid_bytes;
                    s_axis_tlast <= c.last;
                    send_gap <= gap_len();
                end
            end
        end
    end

    // monitor: compare each digest with the oldest prediction
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected digest %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    logic [127:0] e;
                    e = digest_queue.pop_front();
                    if (e[63:0] !== m_axis_tdata[63:0]) begin
                        $error("digest_low expected %h actual %h", e[63:0], m_axis_tdata[63:0]);
                        n_errors++;
                    end
                    if (e[127:64] !== m_axis_tdata[127:64]) begin
                        $error("digest_high expected %h actual %h", e[127:64],
                               m_axis_tdata[127:64]);
                        n_errors++;
                    end
                end
            end
            if (sink_hold) m_axis_tready <= 1'b0;
            else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_gap <= gap_len();
            end
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("aes_round_lane_hash regression: fail");
            $finish;
        end
    end

    function automatic t_chunk rand_chunk(input bit is_last);
        t_chunk c;
        c.chunk_low = {$urandom, $urandom};
        c.chunk_high = {$urandom, $urandom};
        c.last = is_last;
        if (is_last) c.valid_bytes = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                                  : 5'($urandom_range(0, 16));
        else c.valid_bytes = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'd16;
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_chunks.size() != 0 || s_axis_tvalid || digest_queue.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // write one register while idle and mirror it in the predictor
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            arlh_pkg::RegSeed0: seed_words[0] = val;
            arlh_pkg::RegSeed1: seed_words[1] = val;
            arlh_pkg::RegSeed2: seed_words[2] = val;
            arlh_pkg::RegSeed3: seed_words[3] = val;
            arlh_pkg::RegUseSeed: seed_on = val[0];
            default: ;
        endcase
        if (idx <= arlh_pkg::RegUseSeed) rederive();
    endtask

    task automatic push_message(input int unsigned n_full);
        for (int i = 0; i < n_full; i++) pending_chunks.push_back(rand_chunk(1'b0));
        pending_chunks.push_back(rand_chunk(1'b1));
    endtask

    initial begin
        t_chunk c;
        int unsigned sent;
        for (int i = 0; i < 4; i++) seed_words[i] = '0;
        seed_on = 1'b0;
        repeat (6) @(posedge i_clk);
        rederive();
        i_rst_n <= 1'b1;

        // directed: empty message, extremes, short non-last, oversize count, wrap past 8 lanes
        c = '{64'h0, 64'h0, 5'd0, 1'b1}; pending_chunks.push_back(c);
        c = '{'1, '1, 5'd16, 1'b1}; pending_chunks.push_back(c);
        c = '{'1, 64'h0, 5'd31, 1'b1}; pending_chunks.push_back(c);
        c = '{64'h0123456789ABCDEF, '1, 5'd3, 1'b0}; pending_chunks.push_back(c);
        c = '{64'h0, '1, 5'd1, 1'b1}; pending_chunks.push_back(c);
        for (int i = 0; i < 7; i++) pending_chunks.push_back(rand_chunk(1'b0));
        c = '{64'h0, 64'h0, 5'd0, 1'b1}; pending_chunks.push_back(c);
        for (int i = 0; i < 9; i++) pending_chunks.push_back(rand_chunk(1'b0));
        c = '{'1, '1, 5'd15, 1'b1}; pending_chunks.push_back(c);
        wait_drained();

        // seeded with extremes, then an unknown index
        write_reg(arlh_pkg::RegSeed0, '1); write_reg(arlh_pkg::RegSeed1, '1);
        write_reg(arlh_pkg::RegSeed2, '1); write_reg(arlh_pkg::RegSeed3, '1);
        write_reg(arlh_pkg::RegUseSeed, 64'h1);
        write_reg(3'd6, {$urandom, $urandom});
        push_message(0); push_message(3); push_message(8);
        wait_drained();

        // long sink stall while the source keeps offering
        for (int i = 0; i < 12; i++) push_message($urandom_range(0, 2));
        sink_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        sink_hold = 1'b0;
        wait_drained();

        // random phases over several seed settings
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(arlh_pkg::RegSeed0, ph == 1 ? 64'h0 : {$urandom, $urandom});
            write_reg(arlh_pkg::RegSeed1, {$urandom, $urandom});
            write_reg(arlh_pkg::RegSeed2, ph == 1 ? 64'h0 : {$urandom, $urandom});
            write_reg(arlh_pkg::RegSeed3, {$urandom, $urandom});
            write_reg(arlh_pkg::RegUseSeed, 64'(ph % 2 == 0 || ph == 1));
            for (int m = 0; m < 50; m++) begin
                int unsigned n;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
                push_message(n);
                sent += n + 1;
                if (m == 25 && ph == 2) begin
                    // source pause until every digest is back
                    while (pending_chunks.size() != 0 || s_axis_tvalid) @(posedge i_clk);
                    send_pause = 1'b1;
                    while (digest_queue.size() != 0) @(posedge i_clk);
                    send_pause = 1'b0;
                end
                if (sent > 310) break;
            end
            wait_drained();
            sent = 0;
        end

        if (n_errors == 0 && digest_queue.size() == 0)
            $display("aes_round_lane_hash regression: pass");
        else
            $display("aes_round_lane_hash regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/arlh_pkg.sv
design/arlh_ram.sv
design/aes_round_lane_hash.sv
sim/tb_aes_round_lane_hash.sv
